>>> rtl/core/sobel_pkg.sv
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared types and constants of the Sobel edge filter core.
// ----------------------------------------------------------------------------
package sobel_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int FIFO_DEPTH    = 4;

    localparam logic [10:0] WIDTH_RST  = 11'd640;
    localparam logic [15:0] HEIGHT_RST = 16'd480;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_start;
    } t_req;

    typedef struct packed {
        logic [7:0]  grad_x_mag;
        logic [7:0]  grad_y_mag;
        logic [9:0]  center_col;
        logic [15:0] center_row;
    } t_res;

    // new window column, top to bottom
    typedef struct packed {
        logic [7:0] top;
        logic [7:0] mid;
        logic [7:0] bot;
    } t_col;

    // control of the request leaving the line buffer
    typedef struct packed {
        logic        valid;
        logic        produce;
        logic [9:0]  center_col;
        logic [15:0] center_row;
    } t_s1;

endpackage

>>> rtl/core/sobel_cfg.sv
// ----------------------------------------------------------------------------
// sobel_cfg
// APB register file: image width and image height.
// ----------------------------------------------------------------------------
module sobel_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [10:0] o_width,
    output logic [15:0] o_height
);

    logic [10:0]        r_width;
    logic [15:0]        r_height;
    logic               wr_en;
    sobel_pkg::t_reg_idx idx;

    assign idx    = sobel_pkg::t_reg_idx'(paddr[2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= sobel_pkg::WIDTH_RST;
            r_height <= sobel_pkg::HEIGHT_RST;
        end else if (wr_en) begin
            case (idx)
                sobel_pkg::REG_IMAGE_WIDTH:  r_width  <= pwdata[10:0];
                sobel_pkg::REG_IMAGE_HEIGHT: r_height <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            sobel_pkg::REG_IMAGE_WIDTH:  prdata = {21'd0, r_width};
            sobel_pkg::REG_IMAGE_HEIGHT: prdata = {16'd0, r_height};
            default:                     prdata = 32'd0;
        endcase
    end

    assign o_width  = r_width;
    assign o_height = r_height;

endmodule

>>> rtl/core/sobel_line_buf.sv
// ----------------------------------------------------------------------------
// sobel_line_buf
// Position counters, gray conversion and the two line stores, held as one
// read-modify-write memory with forwarding for back-to-back same-column hits.
// ----------------------------------------------------------------------------
module sobel_line_buf #(
    parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  sobel_pkg::t_req   i_req,
    input  logic [10:0]       i_width,
    input  logic [15:0]       i_height,
    output sobel_pkg::t_s1    o_s1,
    output sobel_pkg::t_col   o_col
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMP_W = (COL_W + 1 > 11) ? COL_W + 1 : 11;

    logic [COL_W-1:0] r_col, n_col;
    logic [15:0]      r_row, n_row;
    logic [COL_W-1:0] c;
    logic [15:0]      row;
    logic [CMP_W-1:0] w_ext, w_eff, c_inc;
    logic [16:0]      row_inc;
    logic             wrap;
    logic [12:0]      gray_sum;
    logic [COL_W-1:0] c_dec;
    logic [COL_W+9:0] c_dec_ext;

    logic [15:0]      r_mem [MAX_WIDTH];
    logic [15:0]      r_rd;
    logic             r_fwd_hit;
    logic [15:0]      r_fwd_data;
    logic [15:0]      rd_eff;

    logic             r_s1_valid;
    logic             r_s1_produce;
    logic [COL_W-1:0] r_s1_addr;
    logic [7:0]       r_s1_gray;
    logic [9:0]       r_s1_ccol;
    logic [15:0]      r_s1_crow;

    assign c   = i_req.frame_start ? '0 : r_col;
    assign row = i_req.frame_start ? 16'd0 : r_row;

    assign w_ext   = CMP_W'(i_width);
    assign w_eff   = (w_ext > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : w_ext;
    assign c_inc   = CMP_W'(c) + CMP_W'(1);
    assign wrap    = (c_inc >= w_eff);
    assign row_inc = {1'b0, row} + 17'd1;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            if (wrap) begin
                n_col = '0;
                n_row = (row_inc >= {1'b0, i_height}) ? 16'd0 : row_inc[15:0];
            end else begin
                n_col = c_inc[COL_W-1:0];
                n_row = row;
            end
        end
    end

    assign gray_sum = (13'(i_req.red) * 13'd11) + (13'(i_req.green) << 4)
                    + (13'(i_req.blue) * 13'd5);

    assign c_dec     = c - COL_W'(1);
    assign c_dec_ext = {10'd0, c_dec};

    assign rd_eff = r_fwd_hit ? r_fwd_data : r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= 16'd0;
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= i_accept;
            if (i_accept) begin
                r_fwd_hit <= r_s1_valid && (c == r_s1_addr);
            end
        end
    end

    // memory word: {upper, middle}
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rd <= r_mem[c];
        end
        if (r_s1_valid) begin
            r_mem[r_s1_addr] <= {rd_eff[7:0], r_s1_gray};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_fwd_data   <= {rd_eff[7:0], r_s1_gray};
            r_s1_addr    <= c;
            r_s1_gray    <= gray_sum[12:5];
            r_s1_produce <= (c >= COL_W'(2)) && (row >= 16'd2);
            r_s1_ccol    <= c_dec_ext[9:0];
            r_s1_crow    <= row - 16'd1;
        end
    end

    assign o_s1.valid      = r_s1_valid;
    assign o_s1.produce    = r_s1_produce;
    assign o_s1.center_col = r_s1_ccol;
    assign o_s1.center_row = r_s1_crow;

    assign o_col.top = rd_eff[15:8];
    assign o_col.mid = rd_eff[7:0];
    assign o_col.bot = r_s1_gray;

endmodule

>>> rtl/core/sobel_grad.sv
// ----------------------------------------------------------------------------
// sobel_grad
// 3x3 window shift, weighted column and row sums, then magnitude and
// saturation of both gradients.
// ----------------------------------------------------------------------------
module sobel_grad (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sobel_pkg::t_s1  i_s1,
    input  sobel_pkg::t_col i_col,
    output logic            o_push,
    output sobel_pkg::t_res o_res
);

    // r_win[k][0] is the oldest column, r_win[k][1] the middle one
    logic [7:0] r_win [3][2];

    logic [9:0]  gx_pos, gx_neg, gy_pos, gy_neg;
    logic        r_s2_valid;
    logic [9:0]  r_gx_pos, r_gx_neg, r_gy_pos, r_gy_neg;
    logic [9:0]  r_s2_ccol;
    logic [15:0] r_s2_crow;
    logic [9:0]  gx_abs, gy_abs;

    assign gx_pos = 10'(i_col.top) + (10'(i_col.mid) << 1) + 10'(i_col.bot);
    assign gx_neg = 10'(r_win[0][0]) + (10'(r_win[1][0]) << 1) + 10'(r_win[2][0]);
    assign gy_pos = 10'(r_win[2][0]) + (10'(r_win[2][1]) << 1) + 10'(i_col.bot);
    assign gy_neg = 10'(r_win[0][0]) + (10'(r_win[0][1]) << 1) + 10'(i_col.top);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= 8'd0;
                r_win[k][1] <= 8'd0;
            end
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= i_s1.valid && i_s1.produce;
            if (i_s1.valid) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k][0] <= r_win[k][1];
                end
                r_win[0][1] <= i_col.top;
                r_win[1][1] <= i_col.mid;
                r_win[2][1] <= i_col.bot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s1.valid) begin
            r_gx_pos  <= gx_pos;
            r_gx_neg  <= gx_neg;
            r_gy_pos  <= gy_pos;
            r_gy_neg  <= gy_neg;
            r_s2_ccol <= i_s1.center_col;
            r_s2_crow <= i_s1.center_row;
        end
    end

    assign gx_abs = (r_gx_pos >= r_gx_neg) ? r_gx_pos - r_gx_neg : r_gx_neg - r_gx_pos;
    assign gy_abs = (r_gy_pos >= r_gy_neg) ? r_gy_pos - r_gy_neg : r_gy_neg - r_gy_pos;

    assign o_push           = r_s2_valid;
    assign o_res.grad_x_mag = (gx_abs > 10'd255) ? 8'd255 : gx_abs[7:0];
    assign o_res.grad_y_mag = (gy_abs > 10'd255) ? 8'd255 : gy_abs[7:0];
    assign o_res.center_col = r_s2_ccol;
    assign o_res.center_row = r_s2_crow;

endmodule

>>> rtl/core/sobel_out_fifo.sv
// ----------------------------------------------------------------------------
// sobel_out_fifo
// Small result queue; absorbs the requests in flight when the sink stalls.
// ----------------------------------------------------------------------------
module sobel_out_fifo (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_push,
    input  sobel_pkg::t_res                            i_res,
    input  logic                                       i_ready,
    output logic                                       o_valid,
    output sobel_pkg::t_res                            o_res,
    output logic [$clog2(sobel_pkg::FIFO_DEPTH+1)-1:0] o_count
);

    localparam int DEPTH = sobel_pkg::FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sobel_pkg::t_res  r_buf [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             pop;

    assign pop = o_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_res;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_res   = r_buf[r_rd_ptr];
    assign o_count = r_count;

endmodule

>>> rtl/core/sobel_edge_filter_core.sv
// ----------------------------------------------------------------------------
// sobel_edge_filter_core
// Streaming 3x3 Sobel edge detector on RGB pixels in raster order.
//
//   Channel   Direction  Handshake               Payload
//   pixel     in         i_in_valid/o_in_ready   i_in_req  (sobel_pkg::t_req)
//   gradient  out        o_out_valid/i_out_ready o_out_res (sobel_pkg::t_res)
//   config    in         APB psel/penable        image_width, image_height
//
// One pixel per clock while o_in_ready is high; results pass s1, s2 and the queue.
// Line stores sit in one 16-bit wide memory, read at acceptance and written
// the next cycle; a same-column request straight after is served by forwarding.
// Line stores are not cleared at reset. Input stalls when the four-entry result
// queue plus results in flight could overflow, with no credit for a same-cycle pop.
// ----------------------------------------------------------------------------
module sobel_edge_filter_core #(
    parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  sobel_pkg::t_req i_in_req,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output sobel_pkg::t_res o_out_res,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam int CNT_W = $clog2(sobel_pkg::FIFO_DEPTH + 1);

    logic [10:0]      width;
    logic [15:0]      height;
    logic             accept;
    sobel_pkg::t_s1   s1;
    sobel_pkg::t_col  col;
    logic             push;
    sobel_pkg::t_res  res;
    logic [CNT_W-1:0] fifo_count;
    logic [CNT_W:0]   load;

    sobel_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_width  (width),
        .o_height (height)
    );

    assign accept = i_in_valid & o_in_ready;

    sobel_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_in_req),
        .i_width  (width),
        .i_height (height),
        .o_s1     (s1),
        .o_col    (col)
    );

    sobel_grad u_grad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (s1),
        .i_col   (col),
        .o_push  (push),
        .o_res   (res)
    );

    sobel_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_res   (o_out_res),
        .o_count (fifo_count)
    );

    // queued plus in-flight results must leave a free slot
    assign load = {1'b0, fifo_count} + (CNT_W + 1)'(s1.valid & s1.produce)
                + (CNT_W + 1)'(push);
    assign o_in_ready = (load < (CNT_W + 1)'(sobel_pkg::FIFO_DEPTH));

endmodule

>>> bench/sobel_edge_filter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_filter_checker
// Watches the pixel, gradient and register ports of the Sobel core, keeps its
// own line stores, window and raster counters, and checks every gradient
// request against the oldest predicted one, field by field.
// ----------------------------------------------------------------------------
module sobel_edge_filter_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  sobel_pkg::t_req i_in_req,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  sobel_pkg::t_res i_out_res,
    input  logic            i_psel,
    input  logic            i_penable,
    input  logic            i_pwrite,
    input  logic            i_pready,
    input  logic [2:0]      i_paddr,
    input  logic [31:0]     i_pwdata,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_checked
);
    import sobel_pkg::*;

    localparam int LINE_LEN = MAX_WIDTH_DEF;

    logic [10:0] width_cfg;
    logic [15:0] height_cfg;
    logic [7:0]  upper_line [LINE_LEN];
    logic [7:0]  middle_line [LINE_LEN];
    logic [7:0]  win [3][3];
    int          col_pos;
    int          row_pos;
    t_res        gradients_due [$];

    initial begin
        for (int i = 0; i < LINE_LEN; i++) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
    end

    task automatic flag_error(input string msg);
        if (o_fail_count < 40) begin
            $display("[%0t] sobel mismatch: %s", $realtime, msg);
        end
        o_fail_count++;
    endtask

    function automatic logic [7:0] clip_mag(input int v);
        int m;
        m = (v < 0) ? -v : v;
        return (m > 255) ? 8'd255 : m[7:0];
    endfunction

    // one pixel through the line stores and window; queue a gradient if interior
    task automatic take_pixel(input t_req px);
        int   gray;
        int   line_w;
        int   c;
        int   gx;
        int   gy;
        t_res grad;
        gray   = (11 * int'(px.red) + 16 * int'(px.green) + 5 * int'(px.blue)) >> 5;
        line_w = (int'(width_cfg) > LINE_LEN) ? LINE_LEN : int'(width_cfg);
        if (px.frame_start) begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = upper_line[c];
        win[1][2] = middle_line[c];
        win[2][2] = gray[7:0];
        upper_line[c]  = middle_line[c];
        middle_line[c] = gray[7:0];

        if (c >= 2 && row_pos >= 2) begin
            gx = (int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2]))
               - (int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]));
            gy = (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]))
               - (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]));
            grad.grad_x_mag = clip_mag(gx);
            grad.grad_y_mag = clip_mag(gy);
            grad.center_col = 10'(c - 1);
            grad.center_row = 16'(row_pos - 1);
            gradients_due.push_back(grad);
        end

        c++;
        if (c >= line_w) begin
            c = 0;
            row_pos++;
            if (row_pos >= int'(height_cfg)) begin
                row_pos = 0;
            end
        end
        col_pos = c;
    endtask

    task automatic check_gradient(input t_res got);
        t_res want;
        if (gradients_due.size() == 0) begin
            flag_error($sformatf("gradient x=%0d y=%0d col=%0d row=%0d with none outstanding",
                got.grad_x_mag, got.grad_y_mag, got.center_col, got.center_row));
            return;
        end
        want = gradients_due.pop_front();
        if (got.grad_x_mag != want.grad_x_mag) begin
            flag_error($sformatf("grad_x_mag %0d, want %0d (col %0d row %0d)",
                got.grad_x_mag, want.grad_x_mag, want.center_col, want.center_row));
        end
        if (got.grad_y_mag != want.grad_y_mag) begin
            flag_error($sformatf("grad_y_mag %0d, want %0d (col %0d row %0d)",
                got.grad_y_mag, want.grad_y_mag, want.center_col, want.center_row));
        end
        if (got.center_col != want.center_col) begin
            flag_error($sformatf("center_col %0d, want %0d", got.center_col, want.center_col));
        end
        if (got.center_row != want.center_row) begin
            flag_error($sformatf("center_row %0d, want %0d", got.center_row, want.center_row));
        end
        o_checked++;
    endtask

    // sampled mid-cycle: everything here is what the next rising edge will take
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            width_cfg  = WIDTH_RST;
            height_cfg = HEIGHT_RST;
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    win[r][k] = '0;
                end
            end
            col_pos = 0;
            row_pos = 0;
            gradients_due.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                take_pixel(i_in_req);
            end
            if (i_out_valid && i_out_ready) begin
                check_gradient(i_out_res);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[2]))
                    REG_IMAGE_WIDTH:  width_cfg  = i_pwdata[10:0];
                    REG_IMAGE_HEIGHT: height_cfg = i_pwdata[15:0];
                    default: ;
                endcase
            end
        end
        o_pending = gradients_due.size();
    end

endmodule

>>> bench/tb_sobel_edge_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sobel_edge_filter_core
// Drives RGB frames of many sizes into the Sobel core with random gaps and
// output stalls, changes image size over the register port between frames,
// and leaves the gradient checks to the checker module.
// ----------------------------------------------------------------------------
module tb_sobel_edge_filter_core;
    import sobel_pkg::*;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_PIXELS = 1550;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_req        i_in_req    = '0;
    logic        i_out_ready = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_res        o_out_res;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int checked;
    int cycles        = 0;
    int pixels_sent   = 0;
    int settings_used = 0;
    int hold_offs     = 0;
    int hold_at       = -1;
    bit hold_off_req  = 1'b0;
    bit steady        = 1'b0;

    always #5 i_clk = ~i_clk;

    sobel_edge_filter_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    sobel_edge_filter_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_req     (i_in_req),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_res    (o_out_res),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[sobel_edge_filter_core] ERROR");
        $finish;
    end

    // gradient side: random stalls, plus a long hold-off on request
    initial begin
        int hold_left;
        int pick;
        int stretch;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                hold_left = HOLD_CYCLES;
                while (hold_left > 0) begin
                    @(posedge i_clk);
                    hold_left--;
                end
                hold_off_req = 1'b0;
                hold_offs++;
            end else begin
                pick = $urandom_range(0, 99);
                if (steady || pick < 60) begin
                    i_out_ready <= 1'b1;
                    stretch = $urandom_range(1, 12);
                end else if (pick < 95) begin
                    i_out_ready <= 1'b0;
                    stretch = $urandom_range(1, 3);
                end else begin
                    i_out_ready <= 1'b0;
                    stretch = $urandom_range(10, 40);
                end
                repeat (stretch) @(posedge i_clk);
            end
        end
    end

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (steady || pick < 70) return 0;
        if (pick < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_req rgb_pixel(input logic [23:0] rgb, input bit fs);
        t_req px;
        px.red         = rgb[23:16];
        px.green       = rgb[15:8];
        px.blue        = rgb[7:0];
        px.frame_start = fs;
        return px;
    endfunction

    function automatic t_req random_pixel(input bit fs);
        t_req px;
        if ($urandom_range(0, 9) < 7) begin
            px.red   = 8'($urandom);
            px.green = 8'($urandom);
            px.blue  = 8'($urandom);
        end else begin
            px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        px.frame_start = fs;
        return px;
    endfunction

    // called at a rising edge, returns at the edge that takes the request
    task automatic send_pixel(input t_req px);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (pixels_sent == hold_at) hold_off_req = 1'b1;
        i_in_valid <= 1'b1;
        i_in_req   <= px;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        pixels_sent++;
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // registers change only once every gradient is back and the pipe is empty
    task automatic configure(input int w, input int h);
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        apb_write(REG_IMAGE_WIDTH, 32'(w));
        apb_write(REG_IMAGE_HEIGHT, 32'(h));
        @(posedge i_clk);
        settings_used++;
    endtask

    task automatic run_frame(input int n, input bit noisy);
        bit fs;
        for (int i = 0; i < n; i++) begin
            fs = (i == 0) || (noisy && $urandom_range(0, 199) == 0);
            send_pixel(random_pixel(fs));
        end
    endtask

    initial begin
        logic [23:0] palette [5];
        int w;
        int h;
        int line_w;
        int area;
        int n;
        int frames;
        int rand_start;
        int drain;
        int pick;

        palette[0] = 24'hFF0000;
        palette[1] = 24'h00FF00;
        palette[2] = 24'h0000FF;
        palette[3] = 24'hFFFFFF;
        palette[4] = 24'h000000;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset size: far too few pixels for any gradient
        run_frame(3, 0);

        // quadrant pattern: saturation in both signs on both axes
        configure(4, 4);
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                send_pixel(rgb_pixel(((c >= 2) != (r >= 2)) ? 24'hFFFFFF : 24'h000000,
                                     r == 0 && c == 0));
            end
        end

        // smallest frame, primaries plus white and black
        configure(3, 3);
        for (int k = 0; k < 9; k++) begin
            send_pixel(rgb_pixel(palette[k % 5], k == 0));
        end

        // degenerate sizes never give a gradient
        configure(0, 7);
        run_frame(12, 1);
        configure(1, 5);
        run_frame(6, 1);
        configure(2, 4);
        run_frame(8, 1);
        configure(5, 0);
        run_frame(12, 1);
        configure(5, 1);
        run_frame(8, 1);
        configure(5, 2);
        run_frame(12, 1);
        configure(1024, 2);
        run_frame(20, 0);

        // output held from row 2 on; the full result queue then stalls the rest of the frame
        configure(16, 8);
        hold_at = pixels_sent + 40;
        run_frame(128, 0);

        rand_start = pixels_sent;
        hold_at    = pixels_sent + 600;
        while (pixels_sent - rand_start < RANDOM_PIXELS) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                w = $urandom_range(0, 2);
                h = $urandom_range(0, 10);
            end else if (pick < 8) begin
                w = $urandom_range(3, 12);
                h = $urandom_range(0, 2);
            end else if (pick < 85) begin
                w = $urandom_range(3, 10);
                h = $urandom_range(3, 8);
            end else begin
                w = $urandom_range(11, 64);
                h = $urandom_range(3, 5);
            end
            configure(w, h);
            steady = ($urandom_range(0, 3) == 0);
            line_w = (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w;
            area   = line_w * h;
            if (area == 0) area = $urandom_range(4, 20);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                n = area;
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    n = area + $urandom_range(1, 2 * line_w + 1);
                end else if (pick < 35) begin
                    n = $urandom_range(1, area);
                end
                run_frame(n, 1);
            end
            steady = 1'b0;
        end

        i_in_valid <= 1'b0;
        drain = 0;
        while (pending != 0 && drain < 20000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (10) @(posedge i_clk);

        $display("Covered %0d pixels over %0d image sizes; %0d gradients checked, %0d left over.",
                 pixels_sent, settings_used, checked, pending);
        $display("Output held off %0d times for %0d cycles while pixels kept coming.",
                 hold_offs, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("[sobel_edge_filter_core] OK");
        end else begin
            $display("[sobel_edge_filter_core] ERROR");
        end
        $finish;
    end

endmodule
